FILE: hdl/nggp_pkg.sv
package nggp_pkg;

   // Digits kept after the decimal point for latitude/longitude and altitude.
   localparam int LATLON_FRAC_DIGITS = 5;
   localparam int ALT_FRAC_DIGITS    = 1;

   localparam logic [30:0] LATLON_LIMIT = 31'd1800000000;
   localparam logic [19:0] ALT_LIMIT    = 20'd999999;

   // Time fields seen when the accumulator has saturated at all ones.
   localparam logic [6:0] TIME_SAT_HOUR   = 7'd99;
   localparam logic [6:0] TIME_SAT_MINUTE = 7'd72;
   localparam logic [6:0] TIME_SAT_SECOND = 7'd95;

   // A hemisphere field with more than one character never matches a letter.
   localparam logic [31:0] HEMI_REPEAT = 32'h0000_0100;

   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CHAR_W      = 8'h57;

   typedef enum logic [1:0] {
      OP_CHAR   = 2'd0,
      OP_FINISH = 2'd1,
      OP_EMIT   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ROLE_IGNORE   = 4'd0,
      ROLE_TIME     = 4'd1,
      ROLE_LAT      = 4'd2,
      ROLE_LAT_HEMI = 4'd3,
      ROLE_LON      = 4'd4,
      ROLE_LON_HEMI = 4'd5,
      ROLE_FIX      = 4'd6,
      ROLE_SATS     = 4'd7,
      ROLE_ALT      = 4'd8
   } role_type;

   typedef enum logic [2:0] {
      HDR_IDLE       = 3'd0,
      HDR_GOT_DOLLAR = 3'd1,
      HDR_GOT_G      = 3'd2,
      HDR_GOT_N      = 3'd3,
      HDR_GOT_GNG    = 3'd4,
      HDR_GOT_TYPE   = 3'd5,
      HDR_GOT_A      = 3'd6,
      HDR_BODY       = 3'd7
   } hdr_state_type;

   typedef enum logic [1:0] {
      SENT_GGA  = 2'd0,
      SENT_GSA  = 2'd1,
      SENT_NONE = 2'd3
   } sent_kind_type;

   // One classified character on its way from the front to the back.
   typedef struct packed {
      op_type     op;
      role_type   role;
      logic [7:0] char_code;
      logic       gsa;
   } cmd_type;

endpackage

FILE: hdl/nmea_gga_gsa_sentence_parser_unit.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_in_byte: one ASCII character
// rsp_      out        rsp_valid/rsp_ready   position record per sentence-ending line feed
//
// One character is accepted per clock cycle while req_ready is high. A line feed that
// closes a sentence body goes through the queue and loads the rsp_ output register.
// Synchronous active-high reset idles the header matcher and zeroes the queue
// count and pointers, the field state and the stored record; no clearing pass follows.
// A waiting record stalls only line feeds in the back end; the queue then fills
// and req_ready drops until rsp_ready takes the record.
module nmea_gga_gsa_sentence_parser_unit
   import nggp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_latitude_fixed,
   output logic signed [31:0] rsp_longitude_fixed,
   output logic signed [20:0] rsp_altitude_tenths,
   output logic [3:0]         rsp_fix_quality,
   output logic [7:0]         rsp_satellite_count,
   output logic [6:0]         rsp_utc_hour,
   output logic [6:0]         rsp_utc_minute,
   output logic [6:0]         rsp_utc_second,
   output logic               rsp_sentence_kind
);

   // The front end matches the $GNGGA or $GNGSA header and counts fields. It
   // turns each body character into a command that names the field's role.
   logic    push_valid, push_ready;
   cmd_type push_cmd;

   // Commands wait here, so a stalled back end does not block the front end
   // at once, and the other way round.
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   nggp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   nggp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // The back end accumulates digits, commits each field when it ends, and
   // loads the output register with the whole record at a line feed.
   nggp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (pop_valid),
      .cmd_ready           (pop_ready),
      .cmd                 (pop_cmd),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_latitude_fixed  (rsp_latitude_fixed),
      .rsp_longitude_fixed (rsp_longitude_fixed),
      .rsp_altitude_tenths (rsp_altitude_tenths),
      .rsp_fix_quality     (rsp_fix_quality),
      .rsp_satellite_count (rsp_satellite_count),
      .rsp_utc_hour        (rsp_utc_hour),
      .rsp_utc_minute      (rsp_utc_minute),
      .rsp_utc_second      (rsp_utc_second),
      .rsp_sentence_kind   (rsp_sentence_kind)
   );

endmodule

FILE: hdl/nggp_front.sv
module nggp_front
   import nggp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       push_ready,
   output logic       push_valid,
   output cmd_type    push_cmd
);

   hdr_state_type state_ff, state_in;
   sent_kind_type kind_ff, kind_in;
   logic [4:0]    pos_ff, pos_in;
   logic          accept;

   function automatic role_type field_role(input sent_kind_type kind, input logic [4:0] pos);
      role_type r;
      r = ROLE_IGNORE;
      if (kind == SENT_GSA) begin
         if (pos == 5'd3) r = ROLE_SATS;
      end else if (kind == SENT_GGA) begin
         case (pos)
            5'd1:    r = ROLE_TIME;
            5'd2:    r = ROLE_LAT;
            5'd3:    r = ROLE_LAT_HEMI;
            5'd4:    r = ROLE_LON;
            5'd5:    r = ROLE_LON_HEMI;
            5'd6:    r = ROLE_FIX;
            5'd7:    r = ROLE_SATS;
            5'd9:    r = ROLE_ALT;
            default: r = ROLE_IGNORE;
         endcase
      end
      return r;
   endfunction

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   // Next state: header matching and field position.
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      pos_in   = pos_ff;
      if (accept) begin
         if (req_in_byte == CHAR_DOLLAR) begin
            state_in = HDR_GOT_DOLLAR;
            kind_in  = SENT_NONE;
         end else begin
            case (state_ff)
               HDR_GOT_DOLLAR: state_in = (req_in_byte == CHAR_G) ? HDR_GOT_G : HDR_IDLE;
               HDR_GOT_G:      state_in = (req_in_byte == CHAR_N) ? HDR_GOT_N : HDR_IDLE;
               HDR_GOT_N:      state_in = (req_in_byte == CHAR_G) ? HDR_GOT_GNG : HDR_IDLE;
               HDR_GOT_GNG: begin
                  if (req_in_byte == CHAR_G) begin
                     state_in = HDR_GOT_TYPE;
                     kind_in  = SENT_GGA;
                  end else if (req_in_byte == CHAR_S) begin
                     state_in = HDR_GOT_TYPE;
                     kind_in  = SENT_GSA;
                  end else begin
                     state_in = HDR_IDLE;
                  end
               end
               HDR_GOT_TYPE:   state_in = (req_in_byte == CHAR_A) ? HDR_GOT_A : HDR_IDLE;
               HDR_GOT_A: begin
                  if (req_in_byte == CHAR_COMMA) begin
                     state_in = HDR_BODY;
                     pos_in   = 5'd1;
                  end else begin
                     state_in = HDR_IDLE;
                  end
               end
               HDR_BODY: begin
                  if (req_in_byte == CHAR_COMMA) begin
                     pos_in = (pos_ff == 5'd31) ? pos_ff : pos_ff + 5'd1;
                  end else if (req_in_byte == CHAR_STAR) begin
                     pos_in = 5'd31;
                  end else if (req_in_byte == CHAR_LF) begin
                     state_in = HDR_IDLE;
                     kind_in  = SENT_NONE;
                     pos_in   = 5'd0;
                  end
               end
               default: state_in = HDR_IDLE;
            endcase
         end
      end
   end

   // Outputs: classify body characters, and the comma that ends the header, into commands for the back end.
   always_comb begin
      push_valid         = 1'b0;
      push_cmd.op        = OP_CHAR;
      push_cmd.role      = field_role(kind_ff, pos_ff);
      push_cmd.char_code = req_in_byte;
      push_cmd.gsa       = (kind_ff == SENT_GSA);
      if (accept && req_in_byte != CHAR_DOLLAR) begin
         case (state_ff)
            HDR_GOT_A: begin
               if (req_in_byte == CHAR_COMMA) begin
                  push_valid  = 1'b1;
                  push_cmd.op = OP_CLEAR;
               end
            end
            HDR_BODY: begin
               push_valid = 1'b1;
               if (req_in_byte == CHAR_COMMA || req_in_byte == CHAR_STAR) begin
                  push_cmd.op = OP_FINISH;
               end else if (req_in_byte == CHAR_LF) begin
                  push_cmd.op = OP_EMIT;
               end else begin
                  push_cmd.op = OP_CHAR;
               end
            end
            default: push_valid = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HDR_IDLE;
         kind_ff  <= SENT_NONE;
         pos_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

FILE: hdl/nggp_queue.sv
module nggp_queue
   import nggp_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/nggp_back.sv
module nggp_back
   import nggp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  cmd_type            cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_latitude_fixed,
   output logic signed [31:0] rsp_longitude_fixed,
   output logic signed [20:0] rsp_altitude_tenths,
   output logic [3:0]         rsp_fix_quality,
   output logic [7:0]         rsp_satellite_count,
   output logic [6:0]         rsp_utc_hour,
   output logic [6:0]         rsp_utc_minute,
   output logic [6:0]         rsp_utc_second,
   output logic               rsp_sentence_kind
);

   function automatic logic [19:0] pow10(input logic [2:0] n);
      logic [19:0] p;
      case (n)
         3'd0:    p = 20'd1;
         3'd1:    p = 20'd10;
         3'd2:    p = 20'd100;
         3'd3:    p = 20'd1000;
         3'd4:    p = 20'd10000;
         3'd5:    p = 20'd100000;
         3'd6:    p = 20'd1000000;
         default: p = 20'd0;
      endcase
      return p;
   endfunction

   // Field accumulation state.
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  fdc_ff, fdc_in;
   logic        point_ff, point_in;
   logic        neg_ff, neg_in;
   logic        started_ff, started_in;
   logic        stopped_ff, stopped_in;
   // Running scaled values, kept at or below their limits with a sticky overflow.
   logic [30:0] lat_s_ff, lat_s_in;
   logic        lat_over_ff, lat_over_in;
   logic [19:0] alt_s_ff, alt_s_in;
   logic        alt_over_ff, alt_over_in;
   // Last four decimal digits and the capped count above them, for the time.
   logic [3:0]  dig_ff [4];
   logic [3:0]  dig_in [4];
   logic [6:0]  hq_ff, hq_in;

   // Stored position record.
   logic [31:0] lat_ff, lat_in;
   logic [31:0] lon_ff, lon_in;
   logic [20:0] alt_ff, alt_in;
   logic [3:0]  fix_ff, fix_in;
   logic [7:0]  sats_ff, sats_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_lat_ff, out_lon_ff;
   logic [20:0] out_alt_ff;
   logic [3:0]  out_fix_ff;
   logic [7:0]  out_sats_ff;
   logic [6:0]  out_hour_ff, out_minute_ff, out_second_ff;
   logic        out_kind_ff;

   logic        out_free, take_cmd, emit;
   logic        is_latlon, is_alt, is_int, is_hemi;
   logic        is_digit, is_space;
   logic [3:0]  dval;
   logic [2:0]  lim;
   logic        take_digit;
   logic [35:0] acc_sum;
   logic [31:0] acc_dig;
   logic [2:0]  lat_exp, alt_exp;
   logic [23:0] lat_inc, alt_inc;
   logic [35:0] lat_base, lat_sum;
   logic [25:0] alt_base, alt_sum;
   logic [9:0]  hq_sum;
   logic [31:0] v;
   logic [30:0] lat_mag;
   logic [19:0] alt_mag;
   logic [31:0] scaled_ll;
   logic [20:0] scaled_alt;
   logic [6:0]  t_hour, t_minute, t_second;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign cmd_ready = (cmd.op != OP_EMIT) || out_free;
   assign take_cmd  = cmd_valid && cmd_ready;
   assign emit      = take_cmd && (cmd.op == OP_EMIT);

   assign is_latlon = (cmd.role == ROLE_LAT) || (cmd.role == ROLE_LON);
   assign is_alt    = (cmd.role == ROLE_ALT);
   assign is_int    = (cmd.role == ROLE_TIME) || (cmd.role == ROLE_FIX) ||
                      (cmd.role == ROLE_SATS);
   assign is_hemi   = (cmd.role == ROLE_LAT_HEMI) || (cmd.role == ROLE_LON_HEMI);

   assign is_digit  = (cmd.char_code >= CHAR_ZERO) && (cmd.char_code <= CHAR_NINE);
   assign is_space  = (cmd.char_code == CHAR_SPACE) ||
                      ((cmd.char_code >= CHAR_TAB) && (cmd.char_code <= CHAR_CR));
   assign dval      = cmd.char_code[3:0];
   assign lim       = is_latlon ? 3'(LATLON_FRAC_DIGITS) : 3'(ALT_FRAC_DIGITS);
   assign take_digit = !point_ff || (fdc_ff < lim);

   // Decimal accumulate with saturation at all ones.
   assign acc_sum = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + 36'(dval);
   assign acc_dig = (acc_sum > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : acc_sum[31:0];

   // Scaled latitude/longitude and altitude follow each accepted digit.
   assign lat_exp  = point_ff ? (3'(LATLON_FRAC_DIGITS - 1) - fdc_ff)
                              : 3'(LATLON_FRAC_DIGITS);
   assign lat_inc  = 24'(dval) * 24'(pow10(lat_exp));
   assign lat_base = point_ff ? {5'b0, lat_s_ff}
                              : ({2'b0, lat_s_ff, 3'b000} + {4'b0, lat_s_ff, 1'b0});
   assign lat_sum  = lat_base + 36'(lat_inc);

   assign alt_exp  = point_ff ? (3'(ALT_FRAC_DIGITS - 1) - fdc_ff) : 3'(ALT_FRAC_DIGITS);
   assign alt_inc  = 24'(dval) * 24'(pow10(alt_exp));
   assign alt_base = point_ff ? {6'b0, alt_s_ff}
                              : ({3'b0, alt_s_ff, 3'b000} + {5'b0, alt_s_ff, 1'b0});
   assign alt_sum  = alt_base + 26'(alt_inc);

   assign hq_sum = {hq_ff, 3'b000} + {2'b00, hq_ff, 1'b0} + 10'(dig_ff[3]);

   // Field values at the end of a field.
   assign v          = neg_ff ? 32'd0 : acc_ff;
   assign lat_mag    = lat_over_ff ? LATLON_LIMIT : lat_s_ff;
   assign alt_mag    = alt_over_ff ? ALT_LIMIT : alt_s_ff;
   assign scaled_ll  = neg_ff ? -{1'b0, lat_mag} : {1'b0, lat_mag};
   assign scaled_alt = neg_ff ? -{1'b0, alt_mag} : {1'b0, alt_mag};

   always_comb begin
      if (neg_ff) begin
         t_hour   = 7'd0;
         t_minute = 7'd0;
         t_second = 7'd0;
      end else if (acc_ff == 32'hFFFF_FFFF) begin
         t_hour   = TIME_SAT_HOUR;
         t_minute = TIME_SAT_MINUTE;
         t_second = TIME_SAT_SECOND;
      end else begin
         t_hour   = (hq_ff > 7'd99) ? 7'd99 : hq_ff;
         t_minute = {dig_ff[3], 3'b000} + {2'b00, dig_ff[3], 1'b0} + {3'b000, dig_ff[2]};
         t_second = {dig_ff[1], 3'b000} + {2'b00, dig_ff[1], 1'b0} + {3'b000, dig_ff[0]};
      end
   end

   always_comb begin
      acc_in      = acc_ff;
      fdc_in      = fdc_ff;
      point_in    = point_ff;
      neg_in      = neg_ff;
      started_in  = started_ff;
      stopped_in  = stopped_ff;
      lat_s_in    = lat_s_ff;
      lat_over_in = lat_over_ff;
      alt_s_in    = alt_s_ff;
      alt_over_in = alt_over_ff;
      dig_in      = dig_ff;
      hq_in       = hq_ff;
      lat_in      = lat_ff;
      lon_in      = lon_ff;
      alt_in      = alt_ff;
      fix_in      = fix_ff;
      sats_in     = sats_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;

      if (take_cmd) begin
         if (cmd.op == OP_CHAR) begin
            if (is_hemi) begin
               acc_in     = started_ff ? HEMI_REPEAT : {24'b0, cmd.char_code};
               started_in = 1'b1;
            end else if ((is_int || is_latlon || is_alt) && !stopped_ff) begin
               if (is_digit) begin
                  started_in = 1'b1;
                  if (take_digit) begin
                     acc_in = acc_dig;
                     if (point_ff) fdc_in = fdc_ff + 3'd1;
                     if (is_latlon && !lat_over_ff) begin
                        if (lat_sum > {5'b0, LATLON_LIMIT}) lat_over_in = 1'b1;
                        else lat_s_in = lat_sum[30:0];
                     end
                     if (is_alt && !alt_over_ff) begin
                        if (alt_sum > {6'b0, ALT_LIMIT}) alt_over_in = 1'b1;
                        else alt_s_in = alt_sum[19:0];
                     end
                     if (is_int) begin
                        dig_in[3] = dig_ff[2];
                        dig_in[2] = dig_ff[1];
                        dig_in[1] = dig_ff[0];
                        dig_in[0] = dval;
                        hq_in     = (hq_sum > 10'd100) ? 7'd100 : hq_sum[6:0];
                     end
                  end
               end else if (!started_ff && is_space) begin
                  started_in = started_ff;
               end else if (!started_ff &&
                            (cmd.char_code == CHAR_MINUS || cmd.char_code == CHAR_PLUS)) begin
                  neg_in     = (cmd.char_code == CHAR_MINUS);
                  started_in = 1'b1;
               end else if (cmd.char_code == CHAR_POINT && !is_int && !point_ff) begin
                  point_in   = 1'b1;
                  started_in = 1'b1;
               end else begin
                  stopped_in = 1'b1;
               end
            end
         end else begin
            // A field ends (or a line begins): commit it, then start afresh.
            if (cmd.op != OP_CLEAR) begin
               case (cmd.role)
                  ROLE_TIME: begin
                     hour_in   = t_hour;
                     minute_in = t_minute;
                     second_in = t_second;
                  end
                  ROLE_LAT: lat_in = scaled_ll;
                  ROLE_LAT_HEMI: begin
                     if (started_ff && acc_ff == {24'b0, CHAR_S}) lat_in = -lat_ff;
                  end
                  ROLE_LON: lon_in = scaled_ll;
                  ROLE_LON_HEMI: begin
                     if (started_ff && acc_ff == {24'b0, CHAR_W}) lon_in = -lon_ff;
                  end
                  ROLE_FIX:  fix_in  = (v > 32'd9) ? 4'd9 : v[3:0];
                  ROLE_SATS: sats_in = (v > 32'd255) ? 8'd255 : v[7:0];
                  ROLE_ALT:  alt_in  = scaled_alt;
                  default:   lat_in  = lat_ff;
               endcase
            end
            acc_in      = '0;
            fdc_in      = '0;
            point_in    = 1'b0;
            neg_in      = 1'b0;
            started_in  = 1'b0;
            stopped_in  = 1'b0;
            lat_s_in    = '0;
            lat_over_in = 1'b0;
            alt_s_in    = '0;
            alt_over_in = 1'b0;
            dig_in      = '{default: 4'd0};
            hq_in       = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fdc_ff       <= '0;
         point_ff     <= 1'b0;
         neg_ff       <= 1'b0;
         started_ff   <= 1'b0;
         stopped_ff   <= 1'b0;
         lat_s_ff     <= '0;
         lat_over_ff  <= 1'b0;
         alt_s_ff     <= '0;
         alt_over_ff  <= 1'b0;
         dig_ff       <= '{default: 4'd0};
         hq_ff        <= '0;
         lat_ff       <= '0;
         lon_ff       <= '0;
         alt_ff       <= '0;
         fix_ff       <= '0;
         sats_ff      <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         fdc_ff       <= fdc_in;
         point_ff     <= point_in;
         neg_ff       <= neg_in;
         started_ff   <= started_in;
         stopped_ff   <= stopped_in;
         lat_s_ff     <= lat_s_in;
         lat_over_ff  <= lat_over_in;
         alt_s_ff     <= alt_s_in;
         alt_over_ff  <= alt_over_in;
         dig_ff       <= dig_in;
         hq_ff        <= hq_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         alt_ff       <= alt_in;
         fix_ff       <= fix_in;
         sats_ff      <= sats_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_lat_ff    <= lat_in;
         out_lon_ff    <= lon_in;
         out_alt_ff    <= alt_in;
         out_fix_ff    <= fix_in;
         out_sats_ff   <= sats_in;
         out_hour_ff   <= hour_in;
         out_minute_ff <= minute_in;
         out_second_ff <= second_in;
         out_kind_ff   <= cmd.gsa;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_latitude_fixed  = out_lat_ff;
   assign rsp_longitude_fixed = out_lon_ff;
   assign rsp_altitude_tenths = out_alt_ff;
   assign rsp_fix_quality     = out_fix_ff;
   assign rsp_satellite_count = out_sats_ff;
   assign rsp_utc_hour        = out_hour_ff;
   assign rsp_utc_minute      = out_minute_ff;
   assign rsp_utc_second      = out_second_ff;
   assign rsp_sentence_kind   = out_kind_ff;

endmodule
